/* hw/rtl/ptlru_pkg.sv */
// Shared constants, state codes and control structs of the process id LRU table.
package ptlru_pkg;

   localparam int PID_W           = 22;
   localparam int TIME_W          = 40;
   localparam int SLOT_W          = 7;
   localparam int TABLE_SLOTS_DEF = 128;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_WRITE
   } state_type;

   // Strobes from the sequencer to the shared compare unit.
   typedef struct packed {
      logic valid;
      logic first;
   } scan_ctrl_type;

endpackage

/* hw/rtl/ptlru_if.sv */
// Request and response channel interfaces of the process id LRU table.
interface ptlru_req_if
   import ptlru_pkg::*;
();
   logic              valid;
   logic              ready;
   logic [PID_W-1:0]  pid;
   logic [TIME_W-1:0] now_time;

   modport source (output valid, output pid, output now_time, input ready);
   modport sink   (input valid, input pid, input now_time, output ready);
endinterface

interface ptlru_rsp_if
   import ptlru_pkg::*;
();
   logic              valid;
   logic              ready;
   logic [SLOT_W-1:0] slot;
   logic              hit;
   logic              evicted;
   logic [PID_W-1:0]  evicted_pid;

   modport source (output valid, output slot, output hit, output evicted,
                   output evicted_pid, input ready);
   modport sink   (input valid, input slot, input hit, input evicted,
                   input evicted_pid, output ready);
endinterface

/* hw/rtl/ptlru_ram.sv */
// Generic single write port, single read port RAM with registered read data.
module ptlru_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* hw/rtl/ptlru_scan.sv */
// Shared compare unit: id match and running oldest-entry search, one slot per cycle.
module ptlru_scan
   import ptlru_pkg::*;
#(
   parameter int TABLE_SLOTS = TABLE_SLOTS_DEF
) (
   input  logic                           clock,
   input  scan_ctrl_type                  ctrl,
   input  logic [$clog2(TABLE_SLOTS)-1:0] entry_idx,
   input  logic [PID_W-1:0]               entry_pid,
   input  logic [TIME_W-1:0]              entry_time,
   input  logic [PID_W-1:0]               key_pid,
   output logic                           match,
   output logic [$clog2(TABLE_SLOTS)-1:0] victim_idx,
   output logic [PID_W-1:0]               victim_pid
);

   localparam int IDX_W = $clog2(TABLE_SLOTS);

   logic [TIME_W-1:0] min_time_ff, min_time_in;
   logic [IDX_W-1:0]  victim_idx_ff, victim_idx_in;
   logic [PID_W-1:0]  victim_pid_ff, victim_pid_in;
   logic              take;

   assign match = (entry_pid == key_pid);

   // A strictly smaller time replaces the candidate, so ties keep the lower index.
   assign take = ctrl.valid && (ctrl.first || (entry_time < min_time_ff));

   always_comb begin
      min_time_in   = min_time_ff;
      victim_idx_in = victim_idx_ff;
      victim_pid_in = victim_pid_ff;
      if (take) begin
         min_time_in   = entry_time;
         victim_idx_in = entry_idx;
         victim_pid_in = entry_pid;
      end
   end

   always_ff @(posedge clock) begin
      min_time_ff   <= min_time_in;
      victim_idx_ff <= victim_idx_in;
      victim_pid_ff <= victim_pid_in;
   end

   assign victim_idx = victim_idx_ff;
   assign victim_pid = victim_pid_ff;

endmodule

/* hw/rtl/pid_table_lru_lookup.sv */
// Top level of the fully associative process id table with LRU replacement.
//
// An item on the request channel carries a process id and the current time
// stamp; it is taken when valid and ready are both high. Ready is high only
// while the sequencer is idle, so one item is handled at a time.
// The sequencer walks the occupied slots in index order, one slot per cycle,
// through the single read port of the table RAM and one shared compare unit
// that checks the id and tracks the oldest last-use time. A hit stops the
// walk early; a miss walks every occupied slot, and an empty table is not
// walked at all. Ready returns when the result is loaded into the output
// register, so a new item is taken only once the last one is written.
// The result is held in an output register on the response channel; while
// the receiver stalls, the block may accept and scan the next item, and it
// waits in its write step until the register frees up.
// Reset clears the fill count and the handshake state at once. The table
// contents need no clearing, since only slots below the fill count are read.
module pid_table_lru_lookup
   import ptlru_pkg::*;
#(
   parameter int TABLE_SLOTS = TABLE_SLOTS_DEF
) (
   input  logic         clock,
   input  logic         reset,
   ptlru_req_if.sink    req_chan,
   ptlru_rsp_if.source  rsp_chan
);

   localparam int IDX_W = $clog2(TABLE_SLOTS);
   localparam int CNT_W = $clog2(TABLE_SLOTS + 1);
   localparam int ENT_W = PID_W + TIME_W;

   state_type state_ff, state_in;

   // Fill count and the latched request.
   logic [CNT_W-1:0]  entry_count_ff, entry_count_in;
   logic [PID_W-1:0]  key_pid_ff, key_pid_in;
   logic [TIME_W-1:0] key_time_ff, key_time_in;

   // Read pointer, and which slot the registered RAM data belongs to.
   logic [CNT_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic              data_vld_ff, data_vld_in;
   logic [IDX_W-1:0]  data_idx_ff, data_idx_in;

   // Outcome of the walk.
   logic              hit_ff, hit_in;
   logic [IDX_W-1:0]  hit_idx_ff, hit_idx_in;

   // Response register.
   logic              rsp_valid_ff, rsp_valid_in;
   logic [SLOT_W-1:0] rsp_slot_ff, rsp_slot_in;
   logic              rsp_hit_ff, rsp_hit_in;
   logic              rsp_evicted_ff, rsp_evicted_in;
   logic [PID_W-1:0]  rsp_evpid_ff, rsp_evpid_in;

   // RAM ports.
   logic              wr_en;
   logic [IDX_W-1:0]  wr_addr;
   logic [ENT_W-1:0]  wr_data;
   logic              rd_en;
   logic [ENT_W-1:0]  rd_data;

   // Compare unit.
   scan_ctrl_type     scan_ctrl;
   logic              match;
   logic [IDX_W-1:0]  victim_idx;
   logic [PID_W-1:0]  victim_pid;

   logic              accept;
   logic              full;
   logic              last_entry;
   logic              scan_done;
   logic              out_free;
   logic [IDX_W-1:0]  write_slot;

   assign accept     = req_chan.valid && (state_ff == ST_IDLE);
   assign full       = (entry_count_ff == CNT_W'(TABLE_SLOTS));
   assign last_entry = (CNT_W'(data_idx_ff) == (entry_count_ff - CNT_W'(1)));
   assign scan_done  = (state_ff == ST_SCAN) && data_vld_ff && (match || last_entry);
   assign out_free   = !rsp_valid_ff || rsp_chan.ready;

   assign scan_ctrl.valid = (state_ff == ST_SCAN) && data_vld_ff;
   assign scan_ctrl.first = (data_idx_ff == '0);

   ptlru_ram #(
      .WIDTH (ENT_W),
      .DEPTH (TABLE_SLOTS)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_ptr_ff[IDX_W-1:0]),
      .rd_data (rd_data)
   );

   ptlru_scan #(
      .TABLE_SLOTS (TABLE_SLOTS)
   ) u_scan (
      .clock      (clock),
      .ctrl       (scan_ctrl),
      .entry_idx  (data_idx_ff),
      .entry_pid  (rd_data[ENT_W-1:TIME_W]),
      .entry_time (rd_data[TIME_W-1:0]),
      .key_pid    (key_pid_ff),
      .match      (match),
      .victim_idx (victim_idx),
      .victim_pid (victim_pid)
   );

   // Next state. An empty table has nothing to walk and goes straight to the write.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = (entry_count_ff == '0) ? ST_WRITE : ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (scan_done) begin
               state_in = ST_WRITE;
            end
         end
         ST_WRITE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // The slot that takes the request: the matching one, the next free one, or
   // the oldest one once the table is full.
   always_comb begin
      if (hit_ff) begin
         write_slot = hit_idx_ff;
      end else if (full) begin
         write_slot = victim_idx;
      end else begin
         write_slot = entry_count_ff[IDX_W-1:0];
      end
   end

   // Datapath and outputs.
   always_comb begin
      entry_count_in = entry_count_ff;
      key_pid_in     = key_pid_ff;
      key_time_in    = key_time_ff;
      rd_ptr_in      = rd_ptr_ff;
      data_vld_in    = 1'b0;
      data_idx_in    = data_idx_ff;
      hit_in         = hit_ff;
      hit_idx_in     = hit_idx_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_chan.ready;
      rsp_slot_in    = rsp_slot_ff;
      rsp_hit_in     = rsp_hit_ff;
      rsp_evicted_in = rsp_evicted_ff;
      rsp_evpid_in   = rsp_evpid_ff;
      rd_en          = 1'b0;
      wr_en          = 1'b0;
      wr_addr        = write_slot;
      wr_data        = {key_pid_ff, key_time_ff};

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               key_pid_in  = req_chan.pid;
               key_time_in = req_chan.now_time;
               rd_ptr_in   = '0;
               hit_in      = 1'b0;
            end
         end
         ST_SCAN: begin
            rd_en = (rd_ptr_ff < entry_count_ff) && !scan_done;
            if (rd_en) begin
               rd_ptr_in   = rd_ptr_ff + CNT_W'(1);
               data_vld_in = 1'b1;
               data_idx_in = rd_ptr_ff[IDX_W-1:0];
            end
            if (scan_done && match) begin
               hit_in     = 1'b1;
               hit_idx_in = data_idx_ff;
            end
         end
         ST_WRITE: begin
            if (out_free) begin
               wr_en          = 1'b1;
               rsp_valid_in   = 1'b1;
               rsp_slot_in    = SLOT_W'(write_slot);
               rsp_hit_in     = hit_ff;
               rsp_evicted_in = !hit_ff && full;
               rsp_evpid_in   = (!hit_ff && full) ? victim_pid : '0;
               if (!hit_ff && !full) begin
                  entry_count_in = entry_count_ff + CNT_W'(1);
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         entry_count_ff <= '0;
         data_vld_ff    <= 1'b0;
         hit_ff         <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         entry_count_ff <= entry_count_in;
         data_vld_ff    <= data_vld_in;
         hit_ff         <= hit_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      key_pid_ff     <= key_pid_in;
      key_time_ff    <= key_time_in;
      rd_ptr_ff      <= rd_ptr_in;
      data_idx_ff    <= data_idx_in;
      hit_idx_ff     <= hit_idx_in;
      rsp_slot_ff    <= rsp_slot_in;
      rsp_hit_ff     <= rsp_hit_in;
      rsp_evicted_ff <= rsp_evicted_in;
      rsp_evpid_ff   <= rsp_evpid_in;
   end

   assign req_chan.ready       = (state_ff == ST_IDLE);
   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.slot        = rsp_slot_ff;
   assign rsp_chan.hit         = rsp_hit_ff;
   assign rsp_chan.evicted     = rsp_evicted_ff;
   assign rsp_chan.evicted_pid = rsp_evpid_ff;

   // The fill count never passes the table size.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      entry_count_ff <= CNT_W'(TABLE_SLOTS))
      else $error("fill count beyond table size");

   // Once an item is taken, the block does not take another in the next cycle.
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |=> !req_chan.ready)
      else $error("request taken while busy");

   // An eviction is reported only from a full table and never with a hit.
   a_evict_full: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.evicted) |-> (full && !rsp_chan.hit))
      else $error("eviction without full table");

   // A result without eviction carries a zero evicted id.
   a_evpid_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && !rsp_chan.evicted) |-> (rsp_chan.evicted_pid == '0))
      else $error("evicted id set without eviction");

   // A miss into a table that is not full grows the fill count by one.
   a_count_grow: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WRITE && out_free && !hit_ff && !full)
      |=> (entry_count_ff == $past(entry_count_ff) + CNT_W'(1)))
      else $error("fill count did not grow on miss");

endmodule

/* test/tb.sv */
// Self-checking testbench of the process id LRU table: directed and random lookups.
`timescale 1ns / 1ps

module tb;
   import ptlru_pkg::*;

   // The block under test keeps its default size of 128 slots.
   localparam int TABLE_SLOTS = TABLE_SLOTS_DEF;

   // The hold-off after the queue of expected lookups empties is longer than a
   // full-table scan with some margin, and the watchdog allows many times the
   // slowest gap between handshakes: one full miss, plus the longest sender gap
   // and the longest receiver stall.
   localparam int DRAIN_HOLDOFF  = TABLE_SLOTS + 20;
   localparam int WATCHDOG_LIMIT = 2000;

   // All slots are stamped with this time before the tie-break checks.
   localparam logic [TIME_W-1:0] TIE_STAMP = 40'h40_0000_0000;

   typedef struct packed {
      logic [SLOT_W-1:0] slot;
      logic              hit;
      logic              evicted;
      logic [PID_W-1:0]  evicted_pid;
   } lookup_result_type;

   logic clock = 1'b0;
   logic reset;

   ptlru_req_if req_if ();
   ptlru_rsp_if rsp_if ();

   pid_table_lru_lookup #(
      .TABLE_SLOTS (TABLE_SLOTS)
   ) uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if)
   );

   // Shadow copy of the table: the ids and last-use times of the occupied
   // slots and the fill count. It is updated when a lookup is accepted.
   logic [PID_W-1:0]  shadow_pid [TABLE_SLOTS];
   logic [TIME_W-1:0] shadow_last_use [TABLE_SLOTS];
   int                shadow_fill = 0;

   // Results that the accepted lookups will produce, oldest first.
   lookup_result_type expected_lookups[$];

   int          fail_count   = 0;
   int          quiet_cycles = 0;
   bit          no_idle      = 1'b0;
   logic [TIME_W-1:0] wall_clock = 40'h00_8000_0000;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // ---------------------------------------------------------------------
   // Prediction
   // ---------------------------------------------------------------------

   // Index of the occupied slot that holds the id, or -1 when it is absent.
   // Only slots below the fill count are searched, as in the block.
   function automatic int find_slot(input logic [PID_W-1:0] pid);
      for (int i = 0; i < shadow_fill; i++)
         if (shadow_pid[i] == pid)
            return i;
      return -1;
   endfunction

   // Works out the result of one lookup and applies it to the shadow table.
   // A hit refreshes the last-use time only. A miss fills the next free slot
   // while there is one; after that it replaces the slot with the smallest
   // last-use time, taking the lowest index among equal times. Times are
   // plain unsigned numbers, so a stamp that goes backwards simply makes its
   // slot the oldest one.
   function automatic lookup_result_type predict_lookup(input logic [PID_W-1:0]  pid,
                                                        input logic [TIME_W-1:0] stamp);
      lookup_result_type res;
      int                idx;
      int                victim;
      res = '0;
      idx = find_slot(pid);
      if (idx >= 0) begin
         shadow_last_use[idx] = stamp;
         res.slot = SLOT_W'(idx);
         res.hit  = 1'b1;
         return res;
      end
      if (shadow_fill < TABLE_SLOTS) begin
         victim = shadow_fill;
         shadow_fill++;
      end else begin
         victim = 0;
         for (int i = 1; i < TABLE_SLOTS; i++)
            if (shadow_last_use[i] < shadow_last_use[victim])
               victim = i;
         res.evicted     = 1'b1;
         res.evicted_pid = shadow_pid[victim];
      end
      shadow_pid[victim]      = pid;
      shadow_last_use[victim] = stamp;
      res.slot = SLOT_W'(victim);
      return res;
   endfunction

   // ---------------------------------------------------------------------
   // Idling and stimulus helpers
   // ---------------------------------------------------------------------

   // Idle cycles before the next item or between ready pulses: mostly none
   // or a few, now and then a long stretch. None at all while no_idle is set.
   function automatic int pick_idle_cycles();
      int unsigned pick;
      pick = $urandom_range(99);
      if (no_idle || pick < 60)
         return 0;
      else if (pick < 90)
         return $urandom_range(3, 1);
      else
         return $urandom_range(40, 10);
   endfunction

   // Time stamps: mostly a clock that moves forward, but also copies of
   // times already in the table (to force ties), the two extremes, and
   // fully random values that may well lie in the past.
   function automatic logic [TIME_W-1:0] random_stamp();
      logic [TIME_W-1:0] stamp;
      int unsigned       pick;
      pick = $urandom_range(99);
      if (pick < 50) begin
         wall_clock = wall_clock + $urandom_range(1000);
         stamp = wall_clock;
      end else if (pick < 70 && shadow_fill > 0) begin
         stamp = shadow_last_use[$urandom_range(shadow_fill - 1)];
      end else if (pick < 80) begin
         stamp = pick[0] ? '1 : '0;
      end else begin
         stamp = {8'($urandom), $urandom};
      end
      return stamp;
   endfunction

   // An id that is not in the table at the moment.
   function automatic logic [PID_W-1:0] fresh_pid();
      logic [PID_W-1:0] pid;
      do
         pid = PID_W'($urandom);
      while (find_slot(pid) >= 0);
      return pid;
   endfunction

   // Offers one item after a random gap and waits until it is taken. Valid
   // is left high afterwards, so that the next item can follow at once; it is
   // lowered only at the start of a gap or when the traffic is drained.
   task automatic send_lookup(input logic [PID_W-1:0]  pid,
                              input logic [TIME_W-1:0] stamp);
      int gap;
      gap = pick_idle_cycles();
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid    <= 1'b1;
      req_if.pid      <= pid;
      req_if.now_time <= stamp;
      @(posedge clock);
      while (!req_if.ready)
         @(posedge clock);
      expected_lookups.push_back(predict_lookup(pid, stamp));
   endtask

   // Stops sending, waits until every expected result has come back, and
   // then lets the block sit idle for longer than a full-table scan.
   task automatic drain_lookups();
      req_if.valid <= 1'b0;
      while (expected_lookups.size() != 0)
         @(posedge clock);
      repeat (DRAIN_HOLDOFF) @(posedge clock);
   endtask

   // One random item: hits on resident ids, extreme ids, and random ids that
   // will almost always miss and so evict the least recently used slot.
   task automatic send_random_lookup();
      logic [PID_W-1:0] pid;
      int unsigned      pick;
      pick = $urandom_range(99);
      if (pick < 45 && shadow_fill > 0)
         pid = shadow_pid[$urandom_range(shadow_fill - 1)];
      else if (pick < 55)
         pid = pick[0] ? '1 : '0;
      else
         pid = PID_W'($urandom);
      send_lookup(pid, random_stamp());
   endtask

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------

   // Lookups on an almost empty table: the first miss into slot 0, hits on
   // the extreme ids with extreme times, alternating bit patterns in both
   // fields, and a hit whose time lies before the stored one.
   task automatic test_empty_table();
      send_lookup('0, '0);
      send_lookup('0, '1);
      send_lookup('1, '0);
      send_lookup('1, 40'd123);
      send_lookup(22'h2A_AAAA, 40'hAA_AAAA_AAAA);
      send_lookup(22'h15_5555, 40'h55_5555_5555);
      send_lookup('0, 40'd5);
      send_lookup(22'h15_5555, 40'hFF_FFFF_FFFE);
   endtask

   // Fills the remaining free slots with new ids at random times.
   task automatic test_fill_table();
      while (shadow_fill < TABLE_SLOTS)
         send_lookup(fresh_pid(), random_stamp());
   endtask

   // Every slot is touched with the same time, so the next misses must pick
   // the lowest index among equal oldest times. A miss with time zero then
   // makes its own slot the oldest, and the following miss must replace it.
   task automatic test_tie_eviction();
      for (int i = 0; i < TABLE_SLOTS; i++)
         send_lookup(shadow_pid[i], TIE_STAMP);
      send_lookup(fresh_pid(), TIE_STAMP + 40'd1);
      send_lookup(fresh_pid(), TIE_STAMP + 40'd2);
      send_lookup(fresh_pid(), '0);
      send_lookup(fresh_pid(), '1);
      send_lookup(fresh_pid(), TIE_STAMP);
   endtask

   // Random traffic with random gaps and stalls on both sides.
   task automatic test_random_traffic(input int count);
      repeat (count) send_random_lookup();
   endtask

   // Random traffic with the sender and the receiver never idling.
   task automatic test_back_to_back(input int count);
      no_idle = 1'b1;
      repeat (count) send_random_lookup();
      no_idle = 1'b0;
   endtask

   // ---------------------------------------------------------------------
   // Receiver, checker and watchdog
   // ---------------------------------------------------------------------

   // Ready is pulsed high with random stalls in between.
   initial begin : rsp_ready_gen
      int hold;
      forever begin
         hold = pick_idle_cycles();
         if (hold > 0) begin
            rsp_if.ready <= 1'b0;
            repeat (hold) @(posedge clock);
         end
         rsp_if.ready <= 1'b1;
         @(posedge clock);
      end
   end

   // Each accepted result is compared field by field with the oldest
   // expectation. A result with nothing expected is a failure as well.
   always @(posedge clock) begin : rsp_check
      lookup_result_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (expected_lookups.size() == 0) begin
            $display("%0t: unexpected result, slot %0d hit %0b evicted %0b pid %0h",
                     $time, rsp_if.slot, rsp_if.hit, rsp_if.evicted, rsp_if.evicted_pid);
            fail_count++;
         end else begin
            want = expected_lookups.pop_front();
            if (rsp_if.slot !== want.slot) begin
               $display("%0t: slot mismatch, expected %0d, got %0d",
                        $time, want.slot, rsp_if.slot);
               fail_count++;
            end
            if (rsp_if.hit !== want.hit) begin
               $display("%0t: hit mismatch, expected %0b, got %0b",
                        $time, want.hit, rsp_if.hit);
               fail_count++;
            end
            if (rsp_if.evicted !== want.evicted) begin
               $display("%0t: evicted mismatch, expected %0b, got %0b",
                        $time, want.evicted, rsp_if.evicted);
               fail_count++;
            end
            if (rsp_if.evicted_pid !== want.evicted_pid) begin
               $display("%0t: evicted_pid mismatch, expected %0h, got %0h",
                        $time, want.evicted_pid, rsp_if.evicted_pid);
               fail_count++;
            end
         end
      end
   end

   // Ends the run when no item has moved on either channel for too long.
   always @(posedge clock) begin
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no handshake for %0d cycles", $time, quiet_cycles);
         $display("tb failed");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Test sequence
   // ---------------------------------------------------------------------

   initial begin : run
      reset           <= 1'b1;
      req_if.valid    <= 1'b0;
      req_if.pid      <= '0;
      req_if.now_time <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      test_empty_table();
      test_fill_table();
      test_tie_eviction();
      // The sender holds back here until every result has come in.
      drain_lookups();
      test_random_traffic(220);
      drain_lookups();
      test_back_to_back(200);
      drain_lookups();

      if (fail_count == 0 && expected_lookups.size() == 0)
         $display("tb passed");
      else
         $display("tb failed");
      $finish;
   end

endmodule
